>>> rtl/core/tcls_pkg.sv
// Shared constants, codes and types of the text console line store.
package tcls_pkg;

  localparam int unsigned ROWS_DEF   = 19;
  localparam int unsigned COLS_DEF   = 28;
  localparam int unsigned SCROLL_DEF = 15;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned IDX_W = 5;

  localparam logic [CH_W-1:0] CH_CR = 8'd13;
  localparam logic [CH_W-1:0] CH_LF = 8'd10;

  typedef enum logic {
    MODE_PUT  = 1'b0,
    MODE_READ = 1'b1
  } tcls_mode_e;

  // Cursor and redraw part of one result beat
  typedef struct packed {
    logic [IDX_W-1:0] cursor_row;
    logic [IDX_W-1:0] cursor_col;
    logic             redraw_valid;
    logic             full_redraw;
    logic [IDX_W-1:0] redraw_from;
    logic [IDX_W-1:0] redraw_count;
  } tcls_info_t;

endpackage

>>> rtl/core/tcls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tcls_put.sv
// Cursor, ring and per-write state; turns a put beat into store writes.
module tcls_put #(
  parameter int unsigned ROWS   = tcls_pkg::ROWS_DEF,
  parameter int unsigned COLS   = tcls_pkg::COLS_DEF,
  parameter int unsigned SCROLL = tcls_pkg::SCROLL_DEF,
  localparam int unsigned RowW  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned CntW  = $clog2(ROWS + 1),
  localparam int unsigned LenW  = $clog2(COLS + 1),
  localparam int unsigned AddrW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      put_i,
  input  logic [tcls_pkg::CH_W-1:0] ch_i,
  input  logic                      last_i,
  output tcls_pkg::tcls_info_t      info_o,
  output logic                      char_we_o,
  output logic [AddrW-1:0]          char_addr_o,
  output logic [tcls_pkg::CH_W-1:0] char_wdata_o,
  output logic                      len_we_o,
  output logic [RowW-1:0]           len_addr_o,
  output logic [LenW-1:0]           len_wdata_o
);

  localparam int unsigned Drop = (SCROLL > ROWS) ? ROWS : SCROLL;
  localparam int unsigned IdxW = tcls_pkg::IDX_W;

  logic [RowW-1:0] first_q, first_d;
  logic [CntW-1:0] comp_q, comp_d;
  logic [RowW-1:0] cur_row_q, cur_row_d;
  logic [LenW-1:0] cur_len_q, cur_len_d;
  logic [RowW-1:0] wsr_q, wsr_d;
  logic [CntW-1:0] rcw_q, rcw_d;
  logic            scr_q, scr_d;
  logic            wopen_q, wopen_d;

  logic            is_cr, is_lf, close_row, append;
  logic [RowW-1:0] wsr_e, cur_nx;
  logic [CntW-1:0] rcw_e;
  logic            scr_e;
  logic [CntW:0]   comp_inc;
  logic [RowW:0]   first_sum;

  assign is_cr     = (ch_i == tcls_pkg::CH_CR);
  assign is_lf     = (ch_i == tcls_pkg::CH_LF);
  assign close_row = !is_cr && (is_lf || (32'(cur_len_q) >= COLS));
  assign append    = !is_cr && !is_lf;

  // a put with no write open starts one
  assign wsr_e = wopen_q ? wsr_q : cur_row_q;
  assign rcw_e = wopen_q ? rcw_q : '0;
  assign scr_e = wopen_q ? scr_q : 1'b0;

  assign comp_inc  = {1'b0, comp_q} + (CntW + 1)'(1);
  assign first_sum = {1'b0, first_q} + (RowW + 1)'(Drop);
  assign cur_nx    = (cur_row_q == RowW'(ROWS - 1)) ? '0 : cur_row_q + RowW'(1);

  always_comb begin
    first_d   = first_q;
    comp_d    = comp_q;
    cur_row_d = cur_row_q;
    cur_len_d = cur_len_q;
    rcw_d     = rcw_e;
    scr_d     = scr_e;
    if (close_row) begin
      cur_row_d = cur_nx;
      cur_len_d = '0;
      comp_d    = CntW'(comp_inc);
      if (comp_inc > (CntW + 1)'(ROWS)) begin
        comp_d = CntW'(comp_inc - (CntW + 1)'(Drop));
        first_d = (first_sum >= (RowW + 1)'(ROWS)) ? RowW'(first_sum - (RowW + 1)'(ROWS))
                                                   : RowW'(first_sum);
        scr_d = 1'b1;
      end
      if (32'(rcw_e) < ROWS) begin
        rcw_d = rcw_e + CntW'(1);
      end
    end
    // a row is never full here: a full row was closed above
    if (append) begin
      cur_len_d = cur_len_d + LenW'(1);
    end
  end

  assign wsr_d   = wsr_e;
  assign wopen_d = !last_i;

  assign char_we_o    = put_i && append;
  assign char_addr_o  = AddrW'(32'(cur_row_d) * COLS + 32'(close_row ? '0 : cur_len_q));
  assign char_wdata_o = ch_i;
  assign len_we_o     = put_i && !is_cr;
  assign len_addr_o   = cur_row_d;
  assign len_wdata_o  = cur_len_d;

  always_comb begin
    info_o = '0;
    if (put_i) begin
      info_o.cursor_row = IdxW'(cur_row_d);
      info_o.cursor_col = IdxW'(cur_len_d);
      if (last_i) begin
        info_o.redraw_valid = 1'b1;
        info_o.full_redraw  = scr_d;
        info_o.redraw_from  = scr_d ? IdxW'(first_d) : IdxW'(wsr_e);
        info_o.redraw_count = scr_d ? IdxW'(comp_d) : IdxW'(rcw_d);
      end
    end else begin
      info_o.cursor_row = IdxW'(cur_row_q);
      info_o.cursor_col = IdxW'(cur_len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      comp_q    <= '0;
      cur_row_q <= '0;
      cur_len_q <= '0;
      wsr_q     <= '0;
      rcw_q     <= '0;
      scr_q     <= 1'b0;
      wopen_q   <= 1'b0;
    end else if (put_i) begin
      first_q   <= first_d;
      comp_q    <= comp_d;
      cur_row_q <= cur_row_d;
      cur_len_q <= cur_len_d;
      wsr_q     <= wsr_d;
      rcw_q     <= rcw_d;
      scr_q     <= scr_d;
      wopen_q   <= wopen_d;
    end
  end

  // current row sits right after the completed rows in the ring
  a_ring_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(first_q) + 32'(comp_q) == 32'(cur_row_q)) ||
    (32'(first_q) + 32'(comp_q) == 32'(cur_row_q) + ROWS))
    else $error("cursor row out of step with ring");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_len_q) <= COLS)
    else $error("row length past COLS");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(comp_q) <= ROWS) && (32'(rcw_q) <= ROWS))
    else $error("row count past ROWS");

endmodule

>>> rtl/core/text_console_line_store_core.sv
// Top level of the text console line store: store memories, pipeline and output register.
//
//  channel | direction | handshake               | beat fields
//  --------+-----------+-------------------------+---------------------------------------------
//  in      | in        | in_valid_i / in_stall_o | mode, ch, read_row, read_col, last_of_write
//  out     | out       | out_valid_o/out_stall_i | cell_char, row_length, cursor_row/col,
//          |           |                         | redraw_valid, full_redraw, redraw_from/count
//
//  One beat per cycle sustained while the output is not stalled; a result passes through
//  stage 1 (the registered read of the two store RAMs) and then the output register.
//  Puts update cursor state and write the RAMs at the accepting edge; only characters write both.
//  Reset is immediate: the character RAM is never cleared and row lengths read as
//  zero through one flag per row until the row is first written.
//  An output stall holds the output register, then stage 1, then backs up to in_stall_o.
module text_console_line_store_core #(
  parameter int unsigned ROWS   = tcls_pkg::ROWS_DEF,
  parameter int unsigned COLS   = tcls_pkg::COLS_DEF,
  parameter int unsigned SCROLL = tcls_pkg::SCROLL_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [tcls_pkg::CH_W-1:0]  ch_i,
  input  logic [tcls_pkg::IDX_W-1:0] read_row_i,
  input  logic [tcls_pkg::IDX_W-1:0] read_col_i,
  input  logic                       last_of_write_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcls_pkg::CH_W-1:0]  cell_char_o,
  output logic [tcls_pkg::IDX_W-1:0] row_length_o,
  output logic [tcls_pkg::IDX_W-1:0] cursor_row_o,
  output logic [tcls_pkg::IDX_W-1:0] cursor_col_o,
  output logic                       redraw_valid_o,
  output logic                       full_redraw_o,
  output logic [tcls_pkg::IDX_W-1:0] redraw_from_o,
  output logic [tcls_pkg::IDX_W-1:0] redraw_count_o
);

  localparam int unsigned RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LenW  = $clog2(COLS + 1);
  localparam int unsigned AddrW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
  localparam int unsigned IdxW  = tcls_pkg::IDX_W;
  localparam int unsigned ChW   = tcls_pkg::CH_W;

  // handshake
  logic in_acc, s1_adv, is_read, put_acc, rd_en;

  // put path to the RAMs
  tcls_pkg::tcls_info_t info;
  logic                 char_we, len_we;
  logic [AddrW-1:0]     char_waddr, char_raddr;
  logic [ChW-1:0]       char_wdata, char_rdata;
  logic [RowW-1:0]      len_waddr, len_raddr;
  logic [LenW-1:0]      len_wdata, len_rdata;

  // per-row flag: row length has been written since reset
  logic [ROWS-1:0] len_vld_q, len_vld_d;

  // stage 1: waits for RAM read data
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_hit_q;
  logic [IdxW-1:0]      s1_rcol_q;
  tcls_pkg::tcls_info_t s1_info_q;
  logic [LenW-1:0]      s1_rlen;
  logic [ChW-1:0]       s1_cell;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [ChW-1:0]       out_cell_q;
  logic [LenW-1:0]      out_rlen_q;
  tcls_pkg::tcls_info_t out_info_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_read    = (mode_i == tcls_pkg::MODE_READ);
  assign put_acc    = in_acc && !is_read;
  assign rd_en      = in_acc && is_read;

  assign char_raddr = AddrW'(32'(read_row_i) * COLS + 32'(read_col_i));
  assign len_raddr  = RowW'(read_row_i);

  tcls_put #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .SCROLL (SCROLL)
  ) u_put (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .put_i        (put_acc),
    .ch_i         (ch_i),
    .last_i       (last_of_write_i),
    .info_o       (info),
    .char_we_o    (char_we),
    .char_addr_o  (char_waddr),
    .char_wdata_o (char_wdata),
    .len_we_o     (len_we),
    .len_addr_o   (len_waddr),
    .len_wdata_o  (len_wdata)
  );

  tcls_ram #(
    .WIDTH (ChW),
    .DEPTH (ROWS * COLS)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (char_waddr),
    .wdata_i (char_wdata),
    .re_i    (rd_en),
    .raddr_i (char_raddr),
    .rdata_o (char_rdata)
  );

  tcls_ram #(
    .WIDTH (LenW),
    .DEPTH (ROWS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (rd_en),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // writes land at the accepting edge, so a read beat in a later cycle
  // always sees them: no forwarding needed
  always_comb begin
    len_vld_d = len_vld_q;
    if (len_we) begin
      len_vld_d[len_waddr] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // a miss (put beat, row out of range, row never written) reads as zero
  assign s1_rlen = s1_hit_q ? len_rdata : '0;
  assign s1_cell = (s1_hit_q && (32'(s1_rcol_q) < 32'(len_rdata))) ? char_rdata : '0;

  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_vld_q   <= len_vld_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_hit_q  <= is_read && (32'(read_row_i) < ROWS) && len_vld_q[len_raddr];
      s1_rcol_q <= read_col_i;
      s1_info_q <= info;
    end
    if (s1_valid_q && s1_adv) begin
      out_cell_q <= s1_cell;
      out_rlen_q <= s1_rlen;
      out_info_q <= s1_info_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_char_o    = out_cell_q;
  assign row_length_o   = IdxW'(out_rlen_q);
  assign cursor_row_o   = out_info_q.cursor_row;
  assign cursor_col_o   = out_info_q.cursor_col;
  assign redraw_valid_o = out_info_q.redraw_valid;
  assign full_redraw_o  = out_info_q.full_redraw;
  assign redraw_from_o  = out_info_q.redraw_from;
  assign redraw_count_o = out_info_q.redraw_count;

  // input is held off only when both stages are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_acc_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted beat missing from stage 1");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> (s1_valid_q && out_valid_q))
    else $error("beat dropped under output stall");

endmodule
